[hw/rtl/tebt_pkg.sv]
// Shared types and constants for the tiered energy budget tracker.
package tebt_pkg;

   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_CHANGE  = 3'd1,
      CMD_BOOK1   = 3'd2,
      CMD_BOOK2   = 3'd3,
      CMD_CHECK1  = 3'd4,
      CMD_CHECK2  = 3'd5,
      CMD_NOP6    = 3'd6,
      CMD_NOP7    = 3'd7
   } cmd_type;

   localparam logic [2:0] REG_T0_POWER = 3'd0;
   localparam logic [2:0] REG_T1_POWER = 3'd1;
   localparam logic [2:0] REG_T2_POWER = 3'd2;
   localparam logic [2:0] REG_USABLE   = 3'd3;
   localparam logic [2:0] REG_T1_LIMIT = 3'd4;
   localparam logic [2:0] REG_T2_LIMIT = 3'd5;
   localparam logic [2:0] REG_TARGET   = 3'd6;

   localparam int ENERGY_BITS = 40;
   localparam int OUT_TIME_BITS = 32;
   localparam int CSR_BITS = 40;
   // Energy accumulator width; saturates at all ones, which lies above any budget.
   localparam int ACC_BITS = 64;
   localparam int SECONDS_PER_HOUR = 3600;
   localparam int TIER2_PROBE_S = 600;

endpackage

[hw/rtl/tiered_energy_budget_tracker_top.sv]
// Tiered energy budget tracker: state update plus a sequenced multiply/divide status unit.
//
// One command is taken when req_tvalid and req_tready are high; the block then drops
// req_tready and runs a small sequencer around one shared (max(TIME_BITS, 32) + 1) x
// POWER_BITS multiplier (a register after each product), one shared saturating adder
// and a one-bit-per-cycle restoring divider for remaining time. Before the status is
// loaded into the output register, the command passes one update step, nine
// multiply/compare steps, one step per quotient bit and the output step. req_tready
// returns when the status is loaded, so no new command is taken before the last one
// is through. A status that still waits for its rsp_ transfer holds the following
// command in its output step until the output register is free. Energy values
// saturate at 2^64-1; time counters saturate at TIME_BITS ones.
module tiered_energy_budget_tracker_top #(
   parameter int TIME_BITS  = 32,
   parameter int POWER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata bits from low: cmd[2:0], src_tier[4:3], to_tier[6:5], duration_s[38:7]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata bits from low: remaining_energy_mws[39:0], remaining_time_s[71:40],
   // tier0_used_s[103:72], tier1_used_s[135:104], tier2_used_s[167:136],
   // afford1_ok[168], afford2_ok[169], cur_draw_mw[185:170], check_ok[186]
   output logic [191:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [tebt_pkg::CSR_BITS-1:0] csr_wdata
);

   localparam int EB  = tebt_pkg::ENERGY_BITS;
   localparam int AB  = tebt_pkg::ACC_BITS;
   localparam int WT  = (TIME_BITS > 32) ? TIME_BITS : 32; // time compare width
   localparam int WT1 = WT + 1;
   localparam int MB  = WT + 1; // multiplier time operand
   localparam int PB  = MB + POWER_BITS;
   localparam int CB  = $clog2(EB + 1);
   localparam int EW  = (TIME_BITS + 3 > 33) ? TIME_BITS + 3 : 33;
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

   typedef enum logic [3:0] {
      S_IDLE, S_UPDATE, S_M_SESS, S_M_T0, S_M_T1, S_M_T2, S_M_TGT,
      S_M_P1, S_M_P2, S_M_DUR, S_CMP, S_DIV, S_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [POWER_BITS-1:0] pwr_ff [3];
   logic [EB-1:0]         usable_ff;
   logic [31:0]           lim1_ff, lim2_ff, target_ff;

   // tracker state
   logic [TIME_BITS-1:0] total_ff [3];
   logic [TIME_BITS-1:0] sess_ff;
   logic [1:0]           tier_ff;

   // command
   logic [2:0]   cmd_ff;
   logic [1:0]   from_ff, to_ff;
   logic [31:0]  dur_ff;

   // datapath
   logic [AB-1:0] prod_ff, cons_ff, floor_ff, need1_ff, need2_ff, needd_ff;
   logic [AB-1:0] prod_in;
   logic [MB-1:0] mop_a;
   logic [POWER_BITS-1:0] mop_b;
   logic [PB-1:0] mul_full;
   logic [AB-1:0] acc_a, acc_b, acc_sum;
   logic [AB:0]   acc_wide;
   logic [EB-1:0] rem_ff, quo_ff;
   logic [POWER_BITS-1:0] prem_ff;
   logic [CB-1:0] cnt_ff;
   logic [TIME_BITS+2:0] elapsed;
   logic [EW-1:0] elapsed_w, target_w;
   logic [MB-1:0] tleft;
   logic          can1_ff, can2_ff;
   logic [POWER_BITS-1:0] draw;
   logic [POWER_BITS:0]   trial;
   logic [POWER_BITS+1:0] sub;
   logic [191:0] out_ff;
   logic          rvalid_ff;

   function automatic logic [TIME_BITS-1:0] tadd(input logic [TIME_BITS-1:0] a,
                                                 input logic [WT-1:0] b);
      logic [WT:0] s;
      s = {1'b0, WT'(a)} + {1'b0, b};
      return (s > WT1'(TMAX)) ? TMAX : s[TIME_BITS-1:0];
   endfunction

   function automatic logic [31:0] clamp32(input logic [TIME_BITS:0] v);
      logic [WT:0] x;
      x = WT1'(v);
      return (x > WT1'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : x[31:0];
   endfunction

   // remaining energy is rebuilt from consumption since rem_ff was shifted out
   function automatic logic [191:0] build_out();
      logic [191:0] o;
      logic [EB-1:0] remv;
      logic [31:0]   rt;
      logic [TIME_BITS:0] u0, u1, u2;
      logic ok;
      remv = (AB'(usable_ff) > cons_ff) ? usable_ff - cons_ff[EB-1:0] : '0;
      rt = (draw == '0 || quo_ff > EB'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : quo_ff[31:0];
      u0 = {1'b0, total_ff[0]} + ((tier_ff == 2'd0) ? {1'b0, sess_ff} : '0);
      u1 = {1'b0, total_ff[1]} + ((tier_ff == 2'd1) ? {1'b0, sess_ff} : '0);
      u2 = {1'b0, total_ff[2]} + ((tier_ff == 2'd2) ? {1'b0, sess_ff} : '0);
      ok = 1'b0;
      if (cmd_ff == tebt_pkg::CMD_CHECK1)
         ok = (dur_ff <= lim1_ff) && (needd_ff <= AB'(usable_ff));
      else if (cmd_ff == tebt_pkg::CMD_CHECK2)
         ok = (dur_ff <= lim2_ff) && (needd_ff <= AB'(usable_ff));
      o = '0;
      o[39:0]    = remv;
      o[71:40]   = rt;
      o[103:72]  = clamp32(u0);
      o[135:104] = clamp32(u1);
      o[167:136] = clamp32(u2);
      o[168]     = can1_ff;
      o[169]     = can2_ff;
      o[185:170] = 16'(draw);
      o[186]     = ok;
      return o;
   endfunction

   assign draw = pwr_ff[tier_ff];

   // elapsed time and remaining target time
   assign elapsed = {3'b0, sess_ff} + {3'b0, total_ff[0]} + {3'b0, total_ff[1]}
                    + {3'b0, total_ff[2]};
   assign elapsed_w = EW'(elapsed);
   assign target_w  = EW'(target_ff);
   assign tleft = (elapsed_w >= target_w) ? '0 : MB'(target_w - elapsed_w);

   // shared multiplier operand select
   always_comb begin
      mop_a = '0;
      mop_b = '0;
      unique case (state_ff)
         S_M_SESS: begin mop_a = MB'(sess_ff);     mop_b = draw;      end
         S_M_T0:   begin mop_a = MB'(total_ff[0]); mop_b = pwr_ff[0]; end
         S_M_T1:   begin mop_a = MB'(total_ff[1]); mop_b = pwr_ff[1]; end
         S_M_T2:   begin mop_a = MB'(total_ff[2]); mop_b = pwr_ff[2]; end
         S_M_TGT:  begin mop_a = tleft;            mop_b = pwr_ff[0]; end
         S_M_P1:   begin mop_a = MB'(tebt_pkg::SECONDS_PER_HOUR); mop_b = pwr_ff[1]; end
         S_M_P2:   begin mop_a = MB'(tebt_pkg::TIER2_PROBE_S);    mop_b = pwr_ff[2]; end
         S_M_DUR:  begin
            mop_a = MB'(dur_ff);
            mop_b = (cmd_ff == tebt_pkg::CMD_CHECK2) ? pwr_ff[2] : pwr_ff[1];
         end
         default: ;
      endcase
   end
   assign mul_full = mop_a * mop_b;
   assign prod_in  = AB'(mul_full);

   // shared saturating adder: previous product onto consumption or onto the floor
   always_comb begin
      acc_a = (state_ff == S_M_P2 || state_ff == S_M_DUR || state_ff == S_CMP)
              ? floor_ff : cons_ff;
      acc_b = prod_ff;
      acc_wide = {1'b0, acc_a} + {1'b0, acc_b};
      acc_sum = acc_wide[AB] ? {AB{1'b1}} : acc_wide[AB-1:0];
   end

   assign trial = {prem_ff, rem_ff[EB-1]};
   assign sub   = {1'b0, trial} - {2'b0, draw};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
         pwr_ff[0] <= POWER_BITS'(100);
         pwr_ff[1] <= POWER_BITS'(500);
         pwr_ff[2] <= POWER_BITS'(2000);
         usable_ff <= EB'(35964000);
         lim1_ff   <= 32'd14400;
         lim2_ff   <= 32'd1800;
         target_ff <= 32'd86400;
         total_ff[0] <= '0;
         total_ff[1] <= '0;
         total_ff[2] <= '0;
         sess_ff   <= '0;
         tier_ff   <= 2'd0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               tebt_pkg::REG_T0_POWER: pwr_ff[0] <= csr_wdata[POWER_BITS-1:0];
               tebt_pkg::REG_T1_POWER: pwr_ff[1] <= csr_wdata[POWER_BITS-1:0];
               tebt_pkg::REG_T2_POWER: pwr_ff[2] <= csr_wdata[POWER_BITS-1:0];
               tebt_pkg::REG_USABLE:   usable_ff <= csr_wdata[EB-1:0];
               tebt_pkg::REG_T1_LIMIT: lim1_ff   <= csr_wdata[31:0];
               tebt_pkg::REG_T2_LIMIT: lim2_ff   <= csr_wdata[31:0];
               tebt_pkg::REG_TARGET:   target_ff <= csr_wdata[31:0];
               default: ;
            endcase
         end
         if (rvalid_ff && rsp_tready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               cmd_ff  <= req_tdata[2:0];
               from_ff <= req_tdata[4:3];
               to_ff   <= req_tdata[6:5];
               dur_ff  <= req_tdata[38:7];
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               case (cmd_ff)
                  tebt_pkg::CMD_TICK: sess_ff <= tadd(sess_ff, WT'(1));
                  tebt_pkg::CMD_CHANGE: begin
                     if (from_ff != 2'd3)
                        total_ff[from_ff] <= tadd(total_ff[from_ff], WT'(sess_ff));
                     sess_ff <= '0;
                     tier_ff <= (to_ff == 2'd3) ? 2'd2 : to_ff;
                  end
                  tebt_pkg::CMD_BOOK1:
                     total_ff[1] <= tadd(total_ff[1], WT'(dur_ff));
                  tebt_pkg::CMD_BOOK2:
                     total_ff[2] <= tadd(total_ff[2], WT'(dur_ff));
                  default: ;
               endcase
               cons_ff  <= '0;
               state_ff <= S_M_SESS;
            end
            S_M_SESS: begin prod_ff <= prod_in; state_ff <= S_M_T0; end
            S_M_T0: begin cons_ff <= acc_sum; prod_ff <= prod_in; state_ff <= S_M_T1; end
            S_M_T1: begin cons_ff <= acc_sum; prod_ff <= prod_in; state_ff <= S_M_T2; end
            S_M_T2: begin cons_ff <= acc_sum; prod_ff <= prod_in; state_ff <= S_M_TGT; end
            S_M_TGT: begin
               cons_ff  <= acc_sum;   // all consumed energy
               prod_ff  <= prod_in;
               state_ff <= S_M_P1;
            end
            S_M_P1: begin
               floor_ff <= acc_sum;   // consumed + tier0 floor
               prod_ff  <= prod_in;
               state_ff <= S_M_P2;
            end
            S_M_P2: begin
               need1_ff <= acc_sum;
               prod_ff  <= prod_in;
               state_ff <= S_M_DUR;
            end
            S_M_DUR: begin
               need2_ff <= acc_sum;
               prod_ff  <= prod_in;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               needd_ff <= acc_sum;
               can1_ff <= (need1_ff <= AB'(usable_ff))
                          && (WT'(total_ff[1]) < WT'(lim1_ff));
               can2_ff <= (need2_ff <= AB'(usable_ff))
                          && (WT'(total_ff[2]) < WT'(lim2_ff));
               rem_ff  <= (AB'(usable_ff) > cons_ff) ? usable_ff - cons_ff[EB-1:0] : '0;
               prem_ff <= '0;
               quo_ff  <= '0;
               cnt_ff  <= CB'(EB);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring division, one quotient bit per cycle; rem_ff shifts out dividend
               if (!sub[POWER_BITS+1]) begin
                  prem_ff <= sub[POWER_BITS-1:0];
                  quo_ff  <= {quo_ff[EB-2:0], 1'b1};
               end else begin
                  prem_ff <= trial[POWER_BITS-1:0];
                  quo_ff  <= {quo_ff[EB-2:0], 1'b0};
               end
               rem_ff <= {rem_ff[EB-2:0], 1'b0};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CB'(1)) state_ff <= S_OUT;
            end
            S_OUT: if (!rvalid_ff) begin
               out_ff    <= build_out();
               rvalid_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = out_ff;

endmodule
